// ===== src/mlfr_pkg.sv =====
// Shared types and constants for the monochrome LCD framebuffer refresh block.
package mlfr_pkg;

  // Framebuffer geometry: 64 rows of 16 bytes, one bit per pixel.
  localparam int unsigned FB_DEPTH = 1024;
  localparam int unsigned FB_AW    = 10;

  // Item commands carried in the slave-side tuser.
  localparam logic [1:0] CMD_WRITE   = 2'd0;
  localparam logic [1:0] CMD_REFRESH = 2'd1;
  localparam logic [1:0] CMD_DISP_ON = 2'd2;

  // Controller command bytes.
  localparam logic [7:0] LCD_SET_COLUMN = 8'h40;
  localparam logic [7:0] LCD_SET_PAGE   = 8'hB8;
  localparam logic [7:0] LCD_DISPLAY_ON = 8'h3F;

  // Index of the final byte of each output run.
  localparam logic [3:0] REFRESH_LAST_IDX = 4'd9;
  localparam logic [3:0] DISP_ON_LAST_IDX = 4'd1;

  // Number of framebuffer rows in one tile.
  localparam logic [3:0] TILE_ROWS = 4'd8;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WR_RD,
    ST_WR_MOD,
    ST_WR_SPILL,
    ST_TL_RD,
    ST_EMIT
  } state_e;

endpackage

// ===== src/mlfr_ram.sv =====
// Generic single-port-write, single-port-read synchronous RAM with registered read.
module mlfr_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== src/mono_lcd_framebuffer_refresh.sv =====
// Top level of the monochrome 128x64 LCD framebuffer with tile refresh.
//
// The slave-side channel takes one item per transaction; tuser holds the
// command: write bits into the framebuffer, refresh the next 8x8 tile, or
// switch both controllers on. The master-side channel carries the bytes for
// a two-controller, page-addressed LCD, one byte per transaction, with tlast
// on the final byte of each run.
// A write item reads its byte and writes it back modified, and does the same
// for the next byte of the row when its bits spill into it: one
// read-modify-write of the framebuffer RAM per byte, set by the RAM's single
// read port and its registered read. A refresh item reads the eight rows of
// the tile through that port, then emits ten bytes (column command, page
// command, eight transposed data bytes), one per cycle while the receiver
// keeps tready high. A display-on item emits two bytes.
// After reset the block sweeps the 1024-byte framebuffer to zero, one byte a
// cycle, and keeps tready low until the sweep is done. A stalled receiver
// holds the output register; the block stops emitting until it is taken,
// but takes the next item as soon as the last byte sits in the register.
module mono_lcd_framebuffer_refresh
  import mlfr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata fields from bit 0: pos_x[6:0], pos_y[12:7], pixel_bits[20:13],
  // bit_count[24:21], invert[25], zero fill [31:26].
  input  logic [31:0] s_axis_tdata,
  // tuser fields from bit 0: cmd[1:0].
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tdata fields from bit 0: out_byte[7:0].
  output logic [7:0]  m_axis_tdata,
  // tuser fields from bit 0: chip_right[0], is_data[1].
  output logic [1:0]  m_axis_tuser,
  output logic        m_axis_tlast
);

  // Unpacked input fields.
  logic [6:0] in_pos_x;
  logic [5:0] in_pos_y;
  logic [7:0] in_pixel_bits;
  logic [3:0] in_bit_count;
  logic       in_invert;

  assign in_pos_x      = s_axis_tdata[6:0];
  assign in_pos_y      = s_axis_tdata[12:7];
  assign in_pixel_bits = s_axis_tdata[20:13];
  assign in_bit_count  = s_axis_tdata[24:21];
  assign in_invert     = s_axis_tdata[25];

  state_e state_q, state_d;

  logic             in_accept;
  logic [FB_AW-1:0] clr_cnt_q;
  logic [3:0]       rd_cnt_q;
  logic [3:0]       emit_cnt_q;
  logic             is_refresh_q;
  logic [6:0]       tile_index_q;
  logic [7:0]       tile_q [8];

  // Latched write operation.
  logic [FB_AW-1:0] wr_base_q;
  logic [15:0]      wr_mask_q;
  logic [15:0]      wr_data_q;
  logic             wr_spill_q;

  // Output register.
  logic       m_valid_q;
  logic [7:0] m_byte_q;
  logic       m_chip_q;
  logic       m_isdata_q;
  logic       m_last_q;

  // RAM port signals.
  logic             ram_we;
  logic [FB_AW-1:0] ram_waddr;
  logic [7:0]       ram_wdata;
  logic [FB_AW-1:0] ram_raddr;
  logic [7:0]       ram_rdata;

  assign in_accept = s_axis_tvalid && s_axis_tready;

  // Mask and data of a write. The bit count is clamped to 1..8; the shift
  // places the first bit at pixel column pos_x within a 16-bit window that
  // starts at the byte holding pos_x. Data bits above the count are kept.
  logic [3:0]  wr_n;
  logic [4:0]  wr_sh;
  logic [8:0]  wr_ones;
  logic [15:0] wr_mask;
  logic [15:0] wr_data;

  always_comb begin
    if (in_bit_count == 4'd0) begin
      wr_n = 4'd1;
    end else if (in_bit_count > 4'd8) begin
      wr_n = 4'd8;
    end else begin
      wr_n = in_bit_count;
    end
    wr_sh   = 5'd16 - {1'b0, wr_n} - {2'b00, in_pos_x[2:0]};
    wr_ones = (9'd1 << wr_n) - 9'd1;
    wr_mask = {8'h00, wr_ones[7:0]} << wr_sh;
    wr_data = {8'h00, in_pixel_bits} << wr_sh;
    if (in_invert) begin
      wr_data = wr_data ^ wr_mask;
    end
  end

  // Tile coordinates: the upper four bits pick the tile column (byte of the
  // row), the lower three the page. Columns 8 and up belong to the right chip.
  logic [3:0] tile_col;
  logic [2:0] tile_page;
  logic       tile_chip;

  assign tile_col  = tile_index_q[6:3];
  assign tile_page = tile_index_q[2:0];
  assign tile_chip = tile_col[3];

  // Output byte for the current emit position.
  logic       emit_load;
  logic       emit_last;
  logic [7:0] emit_byte;
  logic       emit_chip;
  logic       emit_isdata;
  logic [2:0] emit_col;
  logic [3:0] emit_ofs;

  assign emit_load = (state_q == ST_EMIT) && (!m_valid_q || m_axis_tready);
  assign emit_last = is_refresh_q ? (emit_cnt_q == REFRESH_LAST_IDX)
                                  : (emit_cnt_q == DISP_ON_LAST_IDX);
  assign emit_ofs  = emit_cnt_q - 4'd2;
  // Data byte i shows pixel column i of the tile, which is bit 7-i of each row.
  assign emit_col  = 3'd7 - emit_ofs[2:0];

  always_comb begin
    emit_byte   = LCD_DISPLAY_ON;
    emit_chip   = 1'b0;
    emit_isdata = 1'b0;
    if (is_refresh_q) begin
      emit_chip = tile_chip;
      case (emit_cnt_q)
        4'd0: emit_byte = LCD_SET_COLUMN | {2'b00, tile_col[2:0], 3'b000};
        4'd1: emit_byte = LCD_SET_PAGE | {5'b00000, tile_page};
        default: begin
          emit_isdata = 1'b1;
          for (int j = 0; j < 8; j++) begin
            emit_byte[j] = tile_q[j][emit_col];
          end
        end
      endcase
    end else begin
      emit_chip = emit_cnt_q[0];
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (clr_cnt_q == FB_AW'(FB_DEPTH - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_accept) begin
          case (s_axis_tuser)
            CMD_WRITE:   state_d = ST_WR_RD;
            CMD_REFRESH: state_d = ST_TL_RD;
            CMD_DISP_ON: state_d = ST_EMIT;
            default:     state_d = ST_IDLE;
          endcase
        end
      end
      ST_WR_RD:    state_d = ST_WR_MOD;
      ST_WR_MOD:   state_d = wr_spill_q ? ST_WR_SPILL : ST_IDLE;
      ST_WR_SPILL: state_d = ST_IDLE;
      ST_TL_RD: begin
        if (rd_cnt_q == TILE_ROWS) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (emit_load && emit_last) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs of the state machine: handshake and RAM port.
  always_comb begin
    s_axis_tready = 1'b0;
    ram_we        = 1'b0;
    ram_waddr     = wr_base_q;
    ram_wdata     = 8'h00;
    ram_raddr     = wr_base_q;
    case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_cnt_q;
      end
      ST_IDLE: s_axis_tready = 1'b1;
      ST_WR_RD: ram_raddr = wr_base_q;
      ST_WR_MOD: begin
        ram_we    = 1'b1;
        ram_waddr = wr_base_q;
        ram_wdata = (ram_rdata & ~wr_mask_q[15:8]) | wr_data_q[15:8];
        ram_raddr = wr_base_q + FB_AW'(1);
      end
      ST_WR_SPILL: begin
        ram_we    = 1'b1;
        ram_waddr = wr_base_q + FB_AW'(1);
        ram_wdata = (ram_rdata & ~wr_mask_q[7:0]) | wr_data_q[7:0];
      end
      ST_TL_RD: ram_raddr = {tile_page, rd_cnt_q[2:0], tile_col};
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLEAR;
      clr_cnt_q    <= '0;
      rd_cnt_q     <= '0;
      emit_cnt_q   <= '0;
      is_refresh_q <= 1'b0;
      tile_index_q <= '0;
      m_valid_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) begin
        clr_cnt_q <= clr_cnt_q + FB_AW'(1);
      end
      if (in_accept) begin
        rd_cnt_q     <= '0;
        emit_cnt_q   <= '0;
        is_refresh_q <= (s_axis_tuser == CMD_REFRESH);
      end
      if (state_q == ST_TL_RD) begin
        rd_cnt_q <= rd_cnt_q + 4'd1;
      end
      if (emit_load) begin
        emit_cnt_q <= emit_cnt_q + 4'd1;
        if (emit_last && is_refresh_q) begin
          tile_index_q <= tile_index_q + 7'd1;
        end
      end
      if (emit_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      wr_base_q  <= {in_pos_y, in_pos_x[6:3]};
      wr_mask_q  <= wr_mask;
      wr_data_q  <= wr_data;
      // The run spills unless the low half is empty or the byte ends the row.
      wr_spill_q <= (wr_mask[7:0] != 8'h00) && (in_pos_x[6:3] != 4'hF);
    end
    if (state_q == ST_TL_RD && rd_cnt_q != 4'd0) begin
      tile_q[rd_cnt_q[2:0] - 3'd1] <= ram_rdata;
    end
    if (emit_load) begin
      m_byte_q   <= emit_byte;
      m_chip_q   <= emit_chip;
      m_isdata_q <= emit_isdata;
      m_last_q   <= emit_last;
    end
  end

  mlfr_ram #(
    .Width(8),
    .Depth(FB_DEPTH)
  ) u_fb_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_byte_q;
  assign m_axis_tuser  = {m_isdata_q, m_chip_q};
  assign m_axis_tlast  = m_last_q;

  // The framebuffer is never written while a tile is read or emitted.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_TL_RD || state_q == ST_EMIT) |-> !ram_we)
    else $error("framebuffer written during tile refresh");

  // The tile counter only moves when the last byte of a refresh is loaded.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(tile_index_q) |-> $past(emit_load && emit_last && is_refresh_q))
    else $error("tile index advanced outside a refresh");

  // A spill write needs bits in the low half and a byte that is not the row end.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WR_SPILL) |->
      (wr_mask_q[7:0] != 8'h00 && wr_base_q[3:0] != 4'hF))
    else $error("spill write without a next byte to modify");

  // The emit counter never passes the end of its run.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT) |-> (emit_cnt_q <= REFRESH_LAST_IDX &&
      (is_refresh_q || emit_cnt_q <= DISP_ON_LAST_IDX)))
    else $error("emit counter out of range");

endmodule

// ===== bench/tb_top.sv =====
// Self-checking testbench for the monochrome LCD framebuffer tile refresh block.
`timescale 1ns / 1ps

module tb_top;
  import mlfr_pkg::*;

  // The block ignores command code three. It is sent only as noise.
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  // The limit is generous. The slowest correct run is the clear after reset,
  // then about 460 items of at most ten bytes each under the longest receiver
  // stall, plus the longest sender gap.
  localparam int CYCLE_LIMIT = 400_000;
  localparam int RANDOM_ITEMS = 430;
  localparam int TAIL_CYCLES = 30;

  // One byte on the LCD-side stream, as the block should produce it.
  typedef struct {
    logic       chip_right;
    logic       is_data;
    logic [7:0] out_byte;
    logic       last;
  } lcd_byte_t;

  // The scoreboard keeps a shadow framebuffer and tile counter. It queues the
  // LCD bytes that each accepted item should produce, and checks the bytes
  // that the block actually sends against them in order.
  class lcd_scoreboard;
    logic [7:0] fb_shadow [FB_DEPTH];
    logic [6:0] next_tile;
    lcd_byte_t  pending_bytes [$];
    int         mismatches;
    int         bytes_checked;
    int         writes_seen;
    int         refreshes_seen;
    int         disp_on_seen;

    function new();
      foreach (fb_shadow[i]) fb_shadow[i] = 8'h00;
      next_tile      = 7'd0;
      mismatches     = 0;
      bytes_checked  = 0;
      writes_seen    = 0;
      refreshes_seen = 0;
      disp_on_seen   = 0;
    endfunction

    function void push_byte(logic chip, logic dat, logic [7:0] b, logic fin);
      lcd_byte_t e;
      e.chip_right = chip;
      e.is_data    = dat;
      e.out_byte   = b;
      e.last       = fin;
      pending_bytes.push_back(e);
    endfunction

    // Apply one accepted item to the shadow state and queue its bytes.
    function void note_item(logic [1:0] cmd, logic [31:0] payload);
      logic [6:0]  x;
      logic [5:0]  y;
      logic [7:0]  bits;
      logic [3:0]  cnt;
      logic        inv;
      int          n;
      int          sh;
      logic [15:0] mask;
      logic [15:0] word;
      logic [9:0]  addr;
      logic [3:0]  col;
      logic [2:0]  page;
      logic [7:0]  column_bits;
      x    = payload[6:0];
      y    = payload[12:7];
      bits = payload[20:13];
      cnt  = payload[24:21];
      inv  = payload[25];
      case (cmd)
        CMD_WRITE: begin
          writes_seen++;
          // A count of zero acts as one, and counts above eight act as eight.
          n = int'(cnt);
          if (n == 0) n = 1;
          if (n > 8) n = 8;
          sh   = 16 - n - int'(x[2:0]);
          mask = 16'(((1 << n) - 1) << sh);
          // Data bits above the count are not masked and land to the left.
          word = 16'(int'(bits) << sh);
          if (inv) word = word ^ mask;
          addr = {y, x[6:3]};
          fb_shadow[addr] = (fb_shadow[addr] & ~mask[15:8]) | word[15:8];
          // The spill into the next byte is dropped at the end of a row.
          if (mask[7:0] != 8'h00 && x[6:3] != 4'hF) begin
            fb_shadow[addr + 10'd1] = (fb_shadow[addr + 10'd1] & ~mask[7:0]) | word[7:0];
          end
        end
        CMD_REFRESH: begin
          refreshes_seen++;
          col  = next_tile[6:3];
          page = next_tile[2:0];
          push_byte(col[3], 1'b0, LCD_SET_COLUMN | {2'b00, col[2:0], 3'b000}, 1'b0);
          push_byte(col[3], 1'b0, LCD_SET_PAGE | {5'b00000, page}, 1'b0);
          // Each data byte is one pixel column of the tile, top row in bit 0.
          for (int i = 0; i < 8; i++) begin
            for (int j = 0; j < 8; j++) begin
              column_bits[j] = fb_shadow[{page, 3'(j), col}][7 - i];
            end
            push_byte(col[3], 1'b1, column_bits, i == 7);
          end
          next_tile = next_tile + 7'd1;
        end
        CMD_DISP_ON: begin
          disp_on_seen++;
          push_byte(1'b0, 1'b0, LCD_DISPLAY_ON, 1'b0);
          push_byte(1'b1, 1'b0, LCD_DISPLAY_ON, 1'b1);
        end
        default: begin
        end
      endcase
    endfunction

    function void compare_field(string name, int expv, int actv);
      if (expv != actv) begin
        mismatches++;
        $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, expv, actv);
      end
    endfunction

    // Compare one accepted LCD byte with the oldest one that is waiting.
    function void check_result(logic chip, logic dat, logic [7:0] b, logic fin);
      lcd_byte_t e;
      if (pending_bytes.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected byte, expected none actual chip=%0h data=%0h byte=%0h last=%0h",
                 $time, chip, dat, b, fin);
      end else begin
        e = pending_bytes.pop_front();
        bytes_checked++;
        compare_field("chip_right", e.chip_right, chip);
        compare_field("is_data", e.is_data, dat);
        compare_field("out_byte", e.out_byte, b);
        compare_field("last", e.last, fin);
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = 32'h0;
  logic [1:0]  s_axis_tuser = CMD_WRITE;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;

  // When no_idle is set, both sides run without gaps or stalls.
  bit no_idle = 1'b0;
  int cyc;
  lcd_scoreboard sb = new();

  mono_lcd_framebuffer_refresh dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #5 clk_i = ~clk_i;

  function automatic logic [31:0] pack_write(logic [6:0] x, logic [5:0] y, logic [7:0] bits,
                                             logic [3:0] cnt, logic inv);
    return {6'b000000, inv, cnt, bits, y, x};
  endfunction

  // Offer one item after a random gap, and hold it until the block takes it.
  // The caller stands at a rising edge. Valid is lowered only when a gap
  // follows, so that a valid held high for the next item is never toggled.
  task automatic send_item(input logic [1:0] cmd, input logic [31:0] payload);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= payload;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_item(cmd, payload);
  endtask

  task automatic wait_drained();
    while (sb.pending_bytes.size() != 0) @(posedge clk_i);
  endtask

  // The receiver draws a stall for each byte, then holds ready until it takes one.
  initial begin
    int stall;
    @(posedge rst_ni);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 8);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid) @(posedge clk_i);
    end
  end

  // Every output transaction is checked at the edge where it is accepted.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      sb.check_result(m_axis_tuser[0], m_axis_tuser[1], m_axis_tdata, m_axis_tlast);
    end
  end

  // The watchdog ends a run that hangs.
  initial begin
    for (cyc = 0; cyc < CYCLE_LIMIT; cyc++) @(posedge clk_i);
    $display("[mono_lcd_framebuffer_refresh] ERROR");
    $finish;
  end

  initial begin
    int         counted;
    int         pick;
    logic [6:0] x;
    logic [5:0] y;
    logic [3:0] cnt;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: the field extremes, every command, and the corner cases.
    send_item(CMD_DISP_ON, 32'h0);
    send_item(CMD_WRITE, pack_write(7'd0, 6'd0, 8'hFF, 4'd8, 1'b0));
    // A write at the far end of the last row drops its spill.
    send_item(CMD_WRITE, pack_write(7'd127, 6'd63, 8'hFF, 4'd8, 1'b0));
    send_item(CMD_WRITE, pack_write(7'd124, 6'd7, 8'h5A, 4'd8, 1'b1));
    // A write that spills into the next byte of the row.
    send_item(CMD_WRITE, pack_write(7'd5, 6'd1, 8'hA5, 4'd8, 1'b0));
    // Data bits above the count are ORed in to the left of the run.
    send_item(CMD_WRITE, pack_write(7'd3, 6'd2, 8'hFF, 4'd2, 1'b0));
    // A count of zero acts as one, and counts above eight act as eight.
    send_item(CMD_WRITE, pack_write(7'd2, 6'd3, 8'h01, 4'd0, 1'b0));
    send_item(CMD_WRITE, pack_write(7'd6, 6'd4, 8'hC3, 4'd15, 1'b0));
    send_item(CMD_WRITE, pack_write(7'd1, 6'd5, 8'h81, 4'd9, 1'b1));
    send_item(CMD_WRITE, pack_write(7'd9, 6'd6, 8'h00, 4'd5, 1'b1));
    send_item(CMD_WRITE, pack_write(7'd7, 6'd7, 8'h00, 4'd1, 1'b1));
    // Command code three is ignored.
    send_item(CMD_UNUSED, 32'h03FF_FFFF);
    send_item(CMD_REFRESH, 32'h0);
    send_item(CMD_REFRESH, 32'h03FF_FFFF);
    send_item(CMD_WRITE, pack_write(7'd64, 6'd32, 8'hFF, 4'd8, 1'b1));
    send_item(CMD_REFRESH, 32'h0);
    send_item(CMD_DISP_ON, 32'h03FF_FFFF);

    // Random part in four phases. The second phase starts from a fully
    // drained block and runs with no idling on either side.
    counted = 0;
    for (int phase = 0; phase < 4; phase++) begin
      if (phase == 1) begin
        s_axis_tvalid <= 1'b0;
        wait_drained();
      end
      no_idle = (phase == 1);
      while (counted < RANDOM_ITEMS * (phase + 1) / 4) begin
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
          x = 7'($urandom_range(0, 127));
          y = 6'($urandom_range(0, 63));
          // Aim half the writes at the tile that is refreshed next.
          if ($urandom_range(0, 1) == 1) begin
            x = {sb.next_tile[6:3], 3'($urandom_range(0, 7))};
            y = {sb.next_tile[2:0], 3'($urandom_range(0, 7))};
          end
          if ($urandom_range(0, 9) < 8) cnt = 4'($urandom_range(1, 8));
          else cnt = 4'($urandom_range(0, 15));
          send_item(CMD_WRITE, pack_write(x, y, 8'($urandom_range(0, 255)), cnt,
                                          1'($urandom_range(0, 1))));
          counted++;
        end else if (pick < 85) begin
          send_item(CMD_REFRESH, $urandom() & 32'h03FF_FFFF);
          counted++;
        end else if (pick < 95) begin
          send_item(CMD_DISP_ON, $urandom() & 32'h03FF_FFFF);
          counted++;
        end else begin
          send_item(CMD_UNUSED, $urandom() & 32'h03FF_FFFF);
        end
      end
    end
    s_axis_tvalid <= 1'b0;

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("Covered %0d writes, %0d tile refreshes and %0d display-on items,",
             sb.writes_seen, sb.refreshes_seen, sb.disp_on_seen);
    $display("with %0d LCD bytes checked and %0d full passes over the tile grid.",
             sb.bytes_checked, sb.refreshes_seen / 128);
    if (sb.mismatches == 0 && sb.pending_bytes.size() == 0) begin
      $display("[mono_lcd_framebuffer_refresh] OK");
    end else begin
      $display("[mono_lcd_framebuffer_refresh] ERROR");
    end
    $finish;
  end

endmodule
